[hw/rtl/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// Fibonacci sphere package
// Shared types, cell kinds, constants and the reciprocal divide helper.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int COORD_W = 16;

    localparam int unsigned Q14_ONE    = 16384;
    localparam int unsigned GOLDEN_Q16 = 25033;
    localparam int unsigned RAD_STEP   = 102944;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

    // Reciprocals for exact floored division of values below 2^30.
    localparam logic [31:0] RCP_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
    localparam logic [31:0] RCP_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
    localparam logic [31:0] RCP_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
    localparam logic [31:0] RCP_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
    localparam logic [31:0] RCP_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
    localparam logic [31:0] RCP_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);

    localparam int N_CELLS = 43;

    typedef enum logic [3:0] {
        K_DIV, K_Y, K_V, K_SQ, K_RND, K_A2, K_H0, K_HM, K_HD, K_OUT
    } cell_kind_t;

    typedef struct packed {
        logic        ok;
        logic        single;
        logic [9:0]  idx;
        logic [11:0] dv;
        logic [15:0] lo;
        logic [11:0] rem;
        logic [15:0] quo;
        logic [15:0] y;
        logic [28:0] sqv;
        logic [14:0] root;
        logic [14:0] rad;
        logic [1:0]  quad;
        logic        swap;
        logic [13:0] g;
        logic [29:0] a;
        logic [29:0] a2;
        logic [30:0] s;
        logic [30:0] c;
        logic [30:0] ts;
        logic [30:0] tc;
        logic [15:0] x;
        logic [15:0] z;
    } pipe_t;

    function automatic cell_kind_t cell_kind(input int i);
        cell_kind_t k;
        if (i < 16)       k = K_DIV;
        else if (i == 16) k = K_Y;
        else if (i == 17) k = K_V;
        else if (i < 33)  k = K_SQ;
        else if (i == 33) k = K_RND;
        else if (i == 34) k = K_A2;
        else if (i == 35) k = K_H0;
        else if (i == 42) k = K_OUT;
        else if ((i % 2) == 0) k = K_HM;
        else              k = K_HD;
        return k;
    endfunction

    function automatic int cell_step(input int i);
        int st;
        if (i >= 18 && i < 33) st = 32 - i;
        else if (i >= 36 && i < 42) st = (i - 34) / 2;
        else st = 0;
        return st;
    endfunction

    function automatic logic [29:0] recip_div(input logic [29:0] v, input logic [31:0] m,
                                              input int sh);
        logic [61:0] p;
        p = 62'(v) * 62'(m);
        return 30'(p >> sh);
    endfunction

endpackage

[hw/rtl/fsp_if.sv]
// ----------------------------------------------------------------------------
// Fibonacci sphere channels
// Index input channel and point output channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsp_idx_if;
    logic       valid;
    logic       ready;
    logic [9:0] point_index;

    modport source (output valid, output point_index, input ready);
    modport sink (input valid, input point_index, output ready);
endinterface

interface fsp_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               valid_res;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output valid_res, input ready);
    modport sink (input valid, input coord_x, input coord_y, input coord_z,
                  input valid_res, output ready);
endinterface

[hw/rtl/fsp_cell.sv]
// ----------------------------------------------------------------------------
// Fibonacci sphere pipeline cell
// One registered step of the point chain, its operation chosen by kind and step.
// ----------------------------------------------------------------------------
module fsp_cell #(
    parameter fsp_pkg::cell_kind_t KIND = fsp_pkg::K_DIV,
    parameter int                  STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fsp_pkg::pipe_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output fsp_pkg::pipe_t  out_data
);
    import fsp_pkg::*;

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    always_comb
    begin
        logic [12:0] sh;
        logic [25:0] pm;
        logic [14:0] ym;
        logic [28:0] ysq;
        logic [30:0] am;
        logic [29:0] trial;
        logic [59:0] sq;
        logic [60:0] ps;
        logic [60:0] pc;
        logic [29:0] mul_a;
        logic [30:0] sg;
        logic [30:0] cg;
        logic [30:0] cm;
        logic [30:0] sm;
        logic        cn;
        logic        sn;
        logic [45:0] xp;
        logic [45:0] zp;
        logic [15:0] xm;
        logic [15:0] zm;
        data_next = in_data;
        sh = {in_data.rem, in_data.lo[15]};
        pm = 26'(in_data.idx) * 26'(GOLDEN_Q16);
        ym = in_data.y[15] ? 15'(-in_data.y) : in_data.y[14:0];
        ysq = 29'(ym) * 29'(ym);
        am = 31'(in_data.g) * 31'(RAD_STEP);
        trial = (30'(in_data.root) << (STEP + 1)) + (30'd1 << (2 * STEP));
        sq = 60'(in_data.a) * 60'(in_data.a);
        mul_a = (STEP == 3) ? in_data.a : in_data.a2;
        ps = 61'(mul_a) * 61'(in_data.s);
        pc = 61'(in_data.a2) * 61'(in_data.c);
        sg = in_data.swap ? in_data.c : in_data.s;
        cg = in_data.swap ? in_data.s : in_data.c;
        case (in_data.quad)
            2'd0:    begin cm = cg; cn = 1'b0; sm = sg; sn = 1'b0; end
            2'd1:    begin cm = sg; cn = 1'b1; sm = cg; sn = 1'b0; end
            2'd2:    begin cm = cg; cn = 1'b1; sm = sg; sn = 1'b1; end
            default: begin cm = sg; cn = 1'b0; sm = cg; sn = 1'b1; end
        endcase
        xp = 46'(cm) * 46'(in_data.rad) + (46'd1 << 29);
        zp = 46'(sm) * 46'(in_data.rad) + (46'd1 << 29);
        xm = 16'(xp >> 30);
        zm = 16'(zp >> 30);
        case (KIND)
            K_DIV:
            begin
                data_next.lo = in_data.lo << 1;
                if (sh >= {1'b0, in_data.dv})
                begin
                    data_next.rem = 12'(sh - {1'b0, in_data.dv});
                    data_next.quo = {in_data.quo[14:0], 1'b1};
                end
                else
                begin
                    data_next.rem = sh[11:0];
                    data_next.quo = {in_data.quo[14:0], 1'b0};
                end
            end
            K_Y:
            begin
                data_next.y = in_data.single ? 16'(Q14_ONE) : 16'(16'(Q14_ONE) - in_data.quo);
                data_next.quad = pm[15:14];
                data_next.swap = pm[13:0] > 14'd8192;
                data_next.g = (pm[13:0] > 14'd8192) ? 14'(15'd16384 - {1'b0, pm[13:0]})
                                                    : pm[13:0];
            end
            K_V:
            begin
                data_next.sqv = (29'd1 << 28) - ysq;
                data_next.root = '0;
                data_next.a = am[29:0];
            end
            K_SQ:
            begin
                if ({1'b0, in_data.sqv} >= trial)
                begin
                    data_next.sqv = 29'({1'b0, in_data.sqv} - trial);
                    data_next.root = in_data.root | (15'd1 << STEP);
                end
            end
            K_RND:
            begin
                data_next.rad = in_data.root + 15'(in_data.sqv > 29'(in_data.root));
            end
            K_A2:
            begin
                data_next.a2 = sq[59:30];
            end
            K_H0:
            begin
                data_next.s = Q30_ONE - 31'(recip_div(in_data.a2, RCP_42, 36));
                data_next.c = Q30_ONE - 31'(recip_div(in_data.a2, RCP_56, 36));
            end
            K_HM:
            begin
                data_next.ts = ps[60:30];
                data_next.tc = pc[60:30];
            end
            K_HD:
            begin
                if (STEP == 1)
                begin
                    data_next.s = Q30_ONE - 31'(recip_div(in_data.ts[29:0], RCP_20, 35));
                    data_next.c = Q30_ONE - 31'(recip_div(in_data.tc[29:0], RCP_30, 35));
                end
                else if (STEP == 2)
                begin
                    data_next.s = Q30_ONE - 31'(recip_div(in_data.ts[29:0], RCP_6, 33));
                    data_next.c = Q30_ONE - 31'(recip_div(in_data.tc[29:0], RCP_12, 34));
                end
                else
                begin
                    data_next.s = in_data.ts;
                    data_next.c = Q30_ONE - (in_data.tc >> 1);
                end
            end
            K_OUT:
            begin
                data_next.x = in_data.ok ? (cn ? 16'(-xm) : xm) : '0;
                data_next.z = in_data.ok ? (sn ? 16'(-zm) : zm) : '0;
                data_next.y = in_data.ok ? in_data.y : '0;
            end
            default:
            begin
                data_next = in_data;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/fibonacci_sphere_point_generator_core.sv]
// ----------------------------------------------------------------------------
// Fibonacci sphere point generator
// Golden-angle spiral points on the unit sphere in Q2.14, one per transaction.
//
//   Channel   Direction  Payload
//   idx_ch    in         point_index[9:0]
//   pt_ch     out        coord_x, coord_y, coord_z (Q2.14), valid_res
//   cfg       in         cfg_we, cfg_wdata[10:0] = point_count
//
// One transaction is accepted per cycle unless a stall has backed up to the
// first cell; each point passes a chain of 43 registered cells (16 divider,
// 15 square-root, Horner cells for the sine and cosine series, one output).
// Reset clears the cell valid bits and sets point_count to 64.
// A stalled output holds the last cell and each full cell behind it; empty cells upstream keep filling.
// ----------------------------------------------------------------------------
module fibonacci_sphere_point_generator_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    fsp_idx_if.sink     idx_ch,
    fsp_pt_if.source    pt_ch
);
    import fsp_pkg::*;

    localparam int unsigned CAP = (MAX_POINTS > 2047) ? 2047 : MAX_POINTS;

    logic [10:0] count_reg;
    logic [10:0] cnt_eff;
    logic [11:0] d_val;
    pipe_t       load;
    pipe_t       lnk_data [0:N_CELLS];
    logic        lnk_valid [0:N_CELLS];
    logic        lnk_ready [0:N_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 11'd64;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    assign cnt_eff = (32'(count_reg) > CAP) ? 11'(CAP) : count_reg;
    assign d_val   = 12'(cnt_eff) - 12'd1;

    always_comb
    begin
        load        = '0;
        load.idx    = idx_ch.point_index;
        load.ok     = 11'(idx_ch.point_index) < cnt_eff;
        load.single = cnt_eff == 11'd1;
        load.dv     = 12'(d_val << 1);
        load.lo     = 16'(d_val);
        load.rem    = 12'(idx_ch.point_index);
    end

    assign lnk_data[0]  = load;
    assign lnk_valid[0] = idx_ch.valid;
    assign idx_ch.ready = lnk_ready[0];

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        fsp_cell #(
            .KIND (cell_kind(i)),
            .STEP (cell_step(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lnk_valid[i]),
            .in_ready  (lnk_ready[i]),
            .in_data   (lnk_data[i]),
            .out_valid (lnk_valid[i + 1]),
            .out_ready (lnk_ready[i + 1]),
            .out_data  (lnk_data[i + 1])
        );
    end

    assign lnk_ready[N_CELLS] = pt_ch.ready;
    assign pt_ch.valid        = lnk_valid[N_CELLS];
    assign pt_ch.coord_x      = lnk_data[N_CELLS].x;
    assign pt_ch.coord_y      = lnk_data[N_CELLS].y;
    assign pt_ch.coord_z      = lnk_data[N_CELLS].z;
    assign pt_ch.valid_res    = lnk_data[N_CELLS].ok;

    a_zero_when_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        pt_ch.valid && !pt_ch.valid_res |->
            pt_ch.coord_x == 16'sd0 && pt_ch.coord_y == 16'sd0 && pt_ch.coord_z == 16'sd0)
        else $error("out-of-range point carries non-zero coordinates");

    a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pt_ch.valid |-> pt_ch.coord_y <= 16'sd16384 && pt_ch.coord_y >= -16'sd16384)
        else $error("coord_y outside the unit range");

    a_ready_when_first_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !lnk_valid[1] |-> idx_ch.ready)
        else $error("input stalled although the first cell is empty");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pt_ch.valid && !pt_ch.ready |=> pt_ch.valid && $stable(pt_ch.coord_x))
        else $error("stalled output point changed");

endmodule
